@@ rtl/core/hpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hpd_pkg: shared definitions for the heading PD differential drive unit
// Widths, arithmetic constants, register map, FSM states and the control
// structs that the top level hands to the serial datapath units.
// ----------------------------------------------------------------------------
package hpd_pkg;

    // Field widths.
    localparam int HEAD_W    = 9;
    localparam int ERR_W     = 9;
    localparam int RAW_W     = ERR_W + 2;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int SPEED_W   = 8;
    localparam int PG_W      = 12;
    localparam int DG_W      = 16;
    localparam int VS_W      = 16;
    localparam int DUTY_W    = 10;

    // Serial arithmetic: two bits of the multiplier per cycle.
    localparam int DIGIT_W   = 2;
    localparam int GAIN_SR_W = 16;
    localparam int MUL_STEPS = GAIN_SR_W / DIGIT_W;
    localparam int PD_PART_W = 12;
    localparam int PD_HI_W   = 14;
    localparam int PD_LO_W   = GAIN_SR_W;
    localparam int ACC_W     = PD_HI_W + PD_LO_W;
    localparam int FRAC_SHIFT = 8;
    localparam int TERM_W    = ACC_W - FRAC_SHIFT;
    localparam int POW_W     = TERM_W + 1;
    localparam int MAG_W     = 7;
    localparam int M_W       = MAG_W + DUTY_W;
    localparam int MH_W      = M_W + 3;
    localparam int VS_FRAC   = 15;
    localparam int Y_W       = 18;
    localparam int DIV_STEPS = DUTY_W;
    localparam int DIVISOR_W = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Arithmetic constants.
    localparam int HALF_TURN   = 180;
    localparam int FULL_TURN   = 360;
    localparam int POWER_LIMIT = 100;
    localparam int DUTY_FULL   = 1023;
    localparam int SAT_LIMIT   = POWER_LIMIT * (DUTY_FULL + 1);
    localparam int DIV_INIT    = POWER_LIMIT * (1 << (DIV_STEPS - 1));

    // Register map (word index) and reset values.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [1:0] REG_VOLT_SCALE = 2'd2;
    localparam logic [PG_W-1:0] PROP_GAIN_RST  = 12'd384;
    localparam logic [DG_W-1:0] DERIV_GAIN_RST = 16'd1920;
    localparam logic [VS_W-1:0] VOLT_SCALE_RST = 16'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PD,
        ST_PWR,
        ST_MUL,
        ST_DIVLD,
        ST_DIV,
        ST_DONE
    } hpd_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } hpd_pd_ctl_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_load;
        logic div_step;
    } hpd_duty_ctl_t;

endpackage

@@ rtl/core/hpd_pd_serial.sv @@
// ----------------------------------------------------------------------------
// hpd_pd_serial: digit-serial PD term
// Forms prop_gain*e - deriv_gain*(prev - e) two gain bits per cycle with a
// right-shifting accumulator, then truncates the Q8 result toward zero.
// ----------------------------------------------------------------------------
module hpd_pd_serial (
    input  logic                                aclk,
    input  hpd_pkg::hpd_pd_ctl_t                ctl,
    input  logic signed [hpd_pkg::ERR_W-1:0]    err,
    input  logic signed [hpd_pkg::ERR_W-1:0]    prev_err,
    input  logic [hpd_pkg::PG_W-1:0]            prop_gain,
    input  logic [hpd_pkg::DG_W-1:0]            deriv_gain,
    output logic signed [hpd_pkg::TERM_W-1:0]   term
);

    logic signed [hpd_pkg::ERR_W-1:0]     err_reg;
    logic signed [hpd_pkg::DIFF_W-1:0]    diff_reg;
    logic [hpd_pkg::GAIN_SR_W-1:0]        pg_sr_reg;
    logic [hpd_pkg::GAIN_SR_W-1:0]        dg_sr_reg;
    logic signed [hpd_pkg::PD_HI_W-1:0]   hi_reg;
    logic [hpd_pkg::PD_LO_W-1:0]          lo_reg;

    logic signed [hpd_pkg::PD_PART_W-1:0] p_part;
    logic signed [hpd_pkg::PD_PART_W-1:0] d_part;
    logic signed [hpd_pkg::PD_HI_W-1:0]   sum;
    logic [hpd_pkg::ACC_W-1:0]            acc;
    logic                                 round_up;

    // One digit of each gain times its operand; both products are small.
    always_comb begin
        p_part = hpd_pkg::PD_PART_W'($signed({1'b0, pg_sr_reg[hpd_pkg::DIGIT_W-1:0]}))
               * hpd_pkg::PD_PART_W'(err_reg);
        d_part = hpd_pkg::PD_PART_W'($signed({1'b0, dg_sr_reg[hpd_pkg::DIGIT_W-1:0]}))
               * hpd_pkg::PD_PART_W'(diff_reg);
        sum    = hi_reg + hpd_pkg::PD_HI_W'(p_part - d_part);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            err_reg   <= err;
            diff_reg  <= hpd_pkg::DIFF_W'(prev_err) - hpd_pkg::DIFF_W'(err);
            pg_sr_reg <= hpd_pkg::GAIN_SR_W'(prop_gain);
            dg_sr_reg <= deriv_gain;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end else if (ctl.step) begin
            pg_sr_reg <= pg_sr_reg >> hpd_pkg::DIGIT_W;
            dg_sr_reg <= dg_sr_reg >> hpd_pkg::DIGIT_W;
            hi_reg    <= sum >>> hpd_pkg::DIGIT_W;
            lo_reg    <= {sum[hpd_pkg::DIGIT_W-1:0],
                          lo_reg[hpd_pkg::PD_LO_W-1:hpd_pkg::DIGIT_W]};
        end
    end

    // Truncation toward zero: a negative sum with fraction bits set rounds up.
    assign acc      = {hi_reg, lo_reg};
    assign round_up = hi_reg[hpd_pkg::PD_HI_W-1] && (|lo_reg[hpd_pkg::FRAC_SHIFT-1:0]);
    assign term     = $signed(acc[hpd_pkg::ACC_W-1:hpd_pkg::FRAC_SHIFT])
                    + $signed({{(hpd_pkg::TERM_W-1){1'b0}}, round_up});

endmodule

@@ rtl/core/hpd_duty_serial.sv @@
// ----------------------------------------------------------------------------
// hpd_duty_serial: motor power to direction and PWM duty
// Clamps the power, scales |power|*1023 by the voltage scale two bits per
// cycle unless turbo is set, then divides by 100 one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpd_duty_serial (
    input  logic                               aclk,
    input  hpd_pkg::hpd_duty_ctl_t             ctl,
    input  logic signed [hpd_pkg::POW_W-1:0]   power,
    input  logic                               turbo,
    input  logic [hpd_pkg::VS_W-1:0]           volt_scale,
    output logic                               dir,
    output logic [hpd_pkg::DUTY_W-1:0]         duty
);

    logic                            dir_reg;
    logic [hpd_pkg::M_W-1:0]         m_reg;
    logic [hpd_pkg::VS_W-1:0]        vs_sr_reg;
    logic [hpd_pkg::MH_W-1:0]        mh_reg;
    logic [hpd_pkg::VS_W-1:0]        ml_reg;
    logic [hpd_pkg::Y_W-1:0]         rem_reg;
    logic [hpd_pkg::DIVISOR_W-1:0]   dvs_reg;
    logic [hpd_pkg::DUTY_W-1:0]      q_reg;
    logic                            sat_reg;

    logic signed [hpd_pkg::POW_W-1:0] pow_abs;
    logic [hpd_pkg::MAG_W-1:0]        mag;
    logic [hpd_pkg::M_W-1:0]          m_next;
    logic [hpd_pkg::MH_W-1:0]         msum;
    logic [hpd_pkg::Y_W-1:0]          y_src;
    logic                             ge;

    always_comb begin
        pow_abs = power[hpd_pkg::POW_W-1] ? -power : power;
        mag     = (pow_abs > hpd_pkg::POW_W'(hpd_pkg::POWER_LIMIT))
                ? hpd_pkg::MAG_W'(hpd_pkg::POWER_LIMIT)
                : pow_abs[hpd_pkg::MAG_W-1:0];
        // mag * 1023 as a shift and a subtract.
        m_next  = (hpd_pkg::M_W'(mag) << hpd_pkg::DUTY_W) - hpd_pkg::M_W'(mag);
        msum    = mh_reg + hpd_pkg::MH_W'(vs_sr_reg[hpd_pkg::DIGIT_W-1:0])
                         * hpd_pkg::MH_W'(m_reg);
        // The scaled product keeps only the bits above the Q1.15 point.
        y_src   = turbo ? hpd_pkg::Y_W'(m_reg)
                        : hpd_pkg::Y_W'({mh_reg, ml_reg[hpd_pkg::VS_W-1]});
        ge      = rem_reg >= hpd_pkg::Y_W'(dvs_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            dir_reg   <= power[hpd_pkg::POW_W-1];
            m_reg     <= m_next;
            vs_sr_reg <= volt_scale;
            mh_reg    <= '0;
            ml_reg    <= '0;
        end
        if (ctl.mul_step) begin
            vs_sr_reg <= vs_sr_reg >> hpd_pkg::DIGIT_W;
            mh_reg    <= msum >> hpd_pkg::DIGIT_W;
            ml_reg    <= {msum[hpd_pkg::DIGIT_W-1:0], ml_reg[hpd_pkg::VS_W-1:hpd_pkg::DIGIT_W]};
        end
        if (ctl.div_load) begin
            rem_reg <= y_src;
            sat_reg <= y_src >= hpd_pkg::Y_W'(hpd_pkg::SAT_LIMIT);
            dvs_reg <= hpd_pkg::DIVISOR_W'(hpd_pkg::DIV_INIT);
            q_reg   <= '0;
        end
        if (ctl.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - hpd_pkg::Y_W'(dvs_reg);
            end
            q_reg   <= {q_reg[hpd_pkg::DUTY_W-2:0], ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign dir  = dir_reg;
    assign duty = sat_reg ? hpd_pkg::DUTY_W'(hpd_pkg::DUTY_FULL) : q_reg;

endmodule

@@ rtl/core/heading_pd_differential_drive_unit.sv @@
// ----------------------------------------------------------------------------
// heading_pd_differential_drive_unit: heading PD steering for two motors
// With turbo the voltage scaling multiply is skipped. The 8-step serial PD
// multiply, the 8-step serial duty scaling and the 10-step divide by 100 run
// one after another on one item, and no new item is taken until the last one
// has left the sequencer. A finished result waits in the output
// register while the next item is taken; a later result is held back while
// that register is still full. Reset is synchronous, active low: it sets the
// gains to their defaults, clears the stored previous error, returns the
// sequencer to idle and clears the output valid.
// ----------------------------------------------------------------------------
module heading_pd_differential_drive_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input item stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [8:0] measured_heading, [17:9] target_heading, [25:18] base_speed
    input  logic [31:0]                   s_tdata,
    // [0] run_motors, [1] turbo
    input  logic [1:0]                    s_tuser,
    // Result item stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [8:0] heading_error, [9] dir_left, [19:10] duty_left,
    // [20] dir_right, [30:21] duty_right
    output logic [31:0]                   m_tdata,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [hpd_pkg::DATA_W-1:0]    pwdata,
    output logic [hpd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Configuration registers.
    logic [hpd_pkg::PG_W-1:0] prop_gain_reg;
    logic [hpd_pkg::DG_W-1:0] deriv_gain_reg;
    logic [hpd_pkg::VS_W-1:0] volt_scale_reg;
    logic                     cfg_write;

    // Sequencer.
    hpd_pkg::hpd_state_t       state_reg, state_next;
    logic [hpd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    hpd_pkg::hpd_pd_ctl_t      pd_ctl;
    hpd_pkg::hpd_duty_ctl_t    duty_ctl;
    logic                      in_accept;
    logic                      out_load;

    // Item registers and the one word of loop state.
    logic signed [hpd_pkg::ERR_W-1:0]   err_reg;
    logic signed [hpd_pkg::ERR_W-1:0]   prev_err_reg;
    logic signed [hpd_pkg::SPEED_W-1:0] speed_reg;
    logic                               run_reg;
    logic                               turbo_reg;

    logic signed [hpd_pkg::RAW_W-1:0]   raw_err;
    logic signed [hpd_pkg::RAW_W-1:0]   wrap_err;
    logic signed [hpd_pkg::TERM_W-1:0]  term;
    logic signed [hpd_pkg::POW_W-1:0]   pow_left;
    logic signed [hpd_pkg::POW_W-1:0]   pow_right;
    logic                               dir_left, dir_right;
    logic [hpd_pkg::DUTY_W-1:0]         duty_left, duty_right;

    // Output register.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // ------------------------------------------------------------------
    // Register port. Writes land in the access phase; reads are a plain
    // mux on the word address. Unmapped addresses read as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= hpd_pkg::PROP_GAIN_RST;
            deriv_gain_reg <= hpd_pkg::DERIV_GAIN_RST;
            volt_scale_reg <= hpd_pkg::VOLT_SCALE_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                hpd_pkg::REG_PROP_GAIN:  prop_gain_reg  <= pwdata[hpd_pkg::PG_W-1:0];
                hpd_pkg::REG_DERIV_GAIN: deriv_gain_reg <= pwdata[hpd_pkg::DG_W-1:0];
                hpd_pkg::REG_VOLT_SCALE: volt_scale_reg <= pwdata[hpd_pkg::VS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hpd_pkg::REG_PROP_GAIN:  prdata = hpd_pkg::DATA_W'(prop_gain_reg);
            hpd_pkg::REG_DERIV_GAIN: prdata = hpd_pkg::DATA_W'(deriv_gain_reg);
            hpd_pkg::REG_VOLT_SCALE: prdata = hpd_pkg::DATA_W'(volt_scale_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Heading error. The raw difference lies in -511..511, and one wrap
    // by a full turn brings it into -180..180, so nine bits suffice.
    // ------------------------------------------------------------------
    always_comb begin
        raw_err = $signed(hpd_pkg::RAW_W'(s_tdata[8:0])) - $signed(hpd_pkg::RAW_W'(s_tdata[17:9]));
        if (raw_err > $signed(hpd_pkg::RAW_W'(hpd_pkg::HALF_TURN))) begin
            wrap_err = raw_err - $signed(hpd_pkg::RAW_W'(hpd_pkg::FULL_TURN));
        end else if (raw_err < -$signed(hpd_pkg::RAW_W'(hpd_pkg::HALF_TURN))) begin
            wrap_err = raw_err + $signed(hpd_pkg::RAW_W'(hpd_pkg::FULL_TURN));
        end else begin
            wrap_err = raw_err;
        end
    end

    assign s_tready  = (state_reg == hpd_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            err_reg   <= hpd_pkg::ERR_W'(wrap_err);
            speed_reg <= $signed(s_tdata[25:18]);
            run_reg   <= s_tuser[0];
            turbo_reg <= s_tuser[1];
        end
    end

    // The previous error follows every item, whether or not the motors run.
    // It is taken over in the same cycle that the PD unit samples the old one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
        end else if (state_reg == hpd_pkg::ST_LOAD) begin
            prev_err_reg <= err_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: load, PD multiply, motor power, optional voltage
    // scaling, divide by 100, then hand the item to the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pd_ctl            = '0;
        duty_ctl          = '0;
        out_load          = 1'b0;
        case (state_reg)
            hpd_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = hpd_pkg::ST_LOAD;
                end
            end
            hpd_pkg::ST_LOAD: begin
                pd_ctl.load = 1'b1;
                cnt_next    = '0;
                state_next  = hpd_pkg::ST_PD;
            end
            hpd_pkg::ST_PD: begin
                pd_ctl.step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == hpd_pkg::CNT_W'(hpd_pkg::MUL_STEPS - 1)) begin
                    state_next = hpd_pkg::ST_PWR;
                end
            end
            hpd_pkg::ST_PWR: begin
                duty_ctl.load = 1'b1;
                cnt_next      = '0;
                state_next    = turbo_reg ? hpd_pkg::ST_DIVLD : hpd_pkg::ST_MUL;
            end
            hpd_pkg::ST_MUL: begin
                duty_ctl.mul_step = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == hpd_pkg::CNT_W'(hpd_pkg::MUL_STEPS - 1)) begin
                    state_next = hpd_pkg::ST_DIVLD;
                end
            end
            hpd_pkg::ST_DIVLD: begin
                duty_ctl.div_load = 1'b1;
                cnt_next          = '0;
                state_next        = hpd_pkg::ST_DIV;
            end
            hpd_pkg::ST_DIV: begin
                duty_ctl.div_step = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == hpd_pkg::CNT_W'(hpd_pkg::DIV_STEPS - 1)) begin
                    state_next = hpd_pkg::ST_DONE;
                end
            end
            hpd_pkg::ST_DONE: begin
                // Wait here only while the previous result is still unclaimed.
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = hpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hpd_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath units. The PD term steers the two motors in opposite senses.
    // ------------------------------------------------------------------
    hpd_pd_serial u_pd (
        .aclk       (aclk),
        .ctl        (pd_ctl),
        .err        (err_reg),
        .prev_err   (prev_err_reg),
        .prop_gain  (prop_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .term       (term)
    );

    assign pow_left  = hpd_pkg::POW_W'(speed_reg) + hpd_pkg::POW_W'(term);
    assign pow_right = hpd_pkg::POW_W'(speed_reg) - hpd_pkg::POW_W'(term);

    hpd_duty_serial u_duty_left (
        .aclk       (aclk),
        .ctl        (duty_ctl),
        .power      (pow_left),
        .turbo      (turbo_reg),
        .volt_scale (volt_scale_reg),
        .dir        (dir_left),
        .duty       (duty_left)
    );

    hpd_duty_serial u_duty_right (
        .aclk       (aclk),
        .ctl        (duty_ctl),
        .power      (pow_right),
        .turbo      (turbo_reg),
        .volt_scale (volt_scale_reg),
        .dir        (dir_right),
        .duty       (duty_right)
    );

    // ------------------------------------------------------------------
    // Output register. With the motors stopped both direction bits and
    // both duties go out as zero; the heading error is always reported.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0,
                            run_reg ? duty_right : {hpd_pkg::DUTY_W{1'b0}},
                            run_reg && dir_right,
                            run_reg ? duty_left : {hpd_pkg::DUTY_W{1'b0}},
                            run_reg && dir_left,
                            err_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input side still ready right after taking an item");

    a_done_hands_off: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg && (state_reg == hpd_pkg::ST_IDLE))
        else $error("finished item not presented or sequencer not back to idle");

    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !run_reg) |=> (m_tdata_reg[30:9] == '0))
        else $error("stopped motors show a nonzero direction or duty");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(m_tdata_reg[8:0]) <= $signed(9'd180))
                      && ($signed(m_tdata_reg[8:0]) >= -$signed(9'd180)))
        else $error("heading error outside a half turn");

endmodule
